>>> hdl/tbur_pkg.sv
// tbur_pkg: shared types, widths and constants for the two-by-two rotation unit
// used by tbur_mac and two_by_two_uncontrollability_rotation_unit; no dependencies

package tbur_pkg;

   // data widths
   localparam int DATA_W = 32;
   localparam int NORM_W = 48;
   localparam int WIDE_W = 64;
   localparam int OPND_W = 33;
   localparam int ACC_W  = 66;
   localparam int STEP_W = 5;

   // parameter defaults
   localparam int FRAC_BITS_DEF  = 16;
   localparam int MAX_ROUNDS_DEF = 3;

   // fixed point constants
   localparam logic signed [DATA_W-1:0] ONE_Q30  = 32'sd1073741824;
   localparam logic signed [ACC_W-1:0]  HALF_Q30 = 66'sd536870912;
   localparam logic [WIDE_W-1:0]        SQRT_BIT_TOP = 64'h4000_0000_0000_0000;

   // step on which each phase writes back or ends
   localparam logic [STEP_W-1:0] WB_SUM3   = 5'd4;
   localparam logic [STEP_W-1:0] WB_SUM2   = 5'd3;
   localparam logic [STEP_W-1:0] WB_SUM1   = 5'd2;
   localparam logic [STEP_W-1:0] SQRT_LAST = 5'd31;
   localparam logic [STEP_W-1:0] DIV_LAST  = 5'd30;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ROUND, ST_M2, ST_M0, ST_RTERM, ST_STERM, ST_NORM,
      ST_HSQ, ST_SQRT, ST_DIVC, ST_DIVS, ST_ROT, ST_DONE
   } state_type;

   // working matrix and vector registers
   typedef enum logic [3:0] {
      R_A00, R_A01, R_A10, R_A11, R_B00, R_B01, R_B10, R_B11, R_V0, R_V1
   } reg_idx_type;

   // element pairs rotated in order within one round
   typedef enum logic [2:0] {
      P_B_COL0, P_B_COL1, P_A_COL0, P_A_COL1, P_A_ROW0, P_A_ROW1, P_V
   } pair_type;

   // multiply-accumulate control
   typedef struct packed {
      logic vld;
      logic first;
      logic neg;
      logic shr2;
   } mac_ctl_type;

   function automatic reg_idx_type pair_x(pair_type p);
      reg_idx_type r;
      case (p)
         P_B_COL0: r = R_B00;
         P_B_COL1: r = R_B01;
         P_A_COL0: r = R_A00;
         P_A_COL1: r = R_A01;
         P_A_ROW0: r = R_A00;
         P_A_ROW1: r = R_A10;
         default:  r = R_V0;
      endcase
      return r;
   endfunction

   function automatic reg_idx_type pair_y(pair_type p);
      reg_idx_type r;
      case (p)
         P_B_COL0: r = R_B10;
         P_B_COL1: r = R_B11;
         P_A_COL0: r = R_A10;
         P_A_COL1: r = R_A11;
         P_A_ROW0: r = R_A01;
         P_A_ROW1: r = R_A11;
         default:  r = R_V1;
      endcase
      return r;
   endfunction

   function automatic logic signed [OPND_W-1:0] sx33(logic signed [DATA_W-1:0] x);
      return {x[DATA_W-1], x};
   endfunction

endpackage

>>> hdl/tbur_mac.sv
// tbur_mac: shared multiplier with registered product and accumulator
// depends on tbur_pkg

module tbur_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  tbur_pkg::mac_ctl_type               ctl,
   input  logic signed [tbur_pkg::OPND_W-1:0]  op_a,
   input  logic signed [tbur_pkg::OPND_W-1:0]  op_b,
   input  logic signed [tbur_pkg::ACC_W-1:0]   preset,
   output logic signed [tbur_pkg::ACC_W-1:0]   acc
);

   tbur_pkg::mac_ctl_type                ctl_ff;
   logic signed [tbur_pkg::ACC_W-1:0]    prod_ff;
   logic signed [tbur_pkg::ACC_W-1:0]    preset_ff;
   logic signed [tbur_pkg::ACC_W-1:0]    acc_ff;
   logic signed [tbur_pkg::ACC_W-1:0]    acc_in;
   logic signed [tbur_pkg::ACC_W-1:0]    term;
   logic signed [tbur_pkg::ACC_W-1:0]    base;

   // control is registered alongside the product
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      prod_ff   <= op_a * op_b;
      preset_ff <= preset;
   end

   // accumulate stage, optional floor shift by two
   always_comb begin
      term   = ctl_ff.shr2 ? (prod_ff >>> 2) : prod_ff;
      base   = ctl_ff.first ? preset_ff : acc_ff;
      acc_in = ctl_ff.neg ? (base - term) : (base + term);
   end

   always_ff @(posedge clock) begin
      if (ctl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

>>> hdl/two_by_two_uncontrollability_rotation_unit.sv
// Two-by-two rotation unit. A request carries matrices A and B (signed Q16.16); the unit
// runs up to MAX_ROUNDS plane rotations while the bottom-row norm keeps falling and returns
// the last norm, the rotated vector (Q1.30) and the rotated matrices. One request is in
// flight at a time: req_ready is high only when idle. Each round computes norms and cross
// terms on the shared 33x33 multiplier, normalizes with one-bit shifts, takes a bit-serial
// square root, runs two bit-serial divisions and rotates the fourteen elements on the
// multiplier. The result then holds until taken.
// File depends on tbur_pkg and tbur_mac.

module two_by_two_uncontrollability_rotation_unit #(
   parameter int FRAC_BITS  = tbur_pkg::FRAC_BITS_DEF,
   parameter int MAX_ROUNDS = tbur_pkg::MAX_ROUNDS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tbur_pkg::DATA_W-1:0]   req_a_top_left,
   input  logic signed [tbur_pkg::DATA_W-1:0]   req_a_top_right,
   input  logic signed [tbur_pkg::DATA_W-1:0]   req_a_bottom_left,
   input  logic signed [tbur_pkg::DATA_W-1:0]   req_a_bottom_right,
   input  logic signed [tbur_pkg::DATA_W-1:0]   req_b_top_left,
   input  logic signed [tbur_pkg::DATA_W-1:0]   req_b_top_right,
   input  logic signed [tbur_pkg::DATA_W-1:0]   req_b_bottom_left,
   input  logic signed [tbur_pkg::DATA_W-1:0]   req_b_bottom_right,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tbur_pkg::NORM_W-1:0]          rsp_residual_norm,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_v_first,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_v_second,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_rot_a_top_left,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_rot_a_top_right,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_rot_a_bottom_left,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_rot_a_bottom_right,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_rot_b_top_left,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_rot_b_top_right,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_rot_b_bottom_left,
   output logic signed [tbur_pkg::DATA_W-1:0]   rsp_rot_b_bottom_right
);

   localparam int CNT_W = $clog2(MAX_ROUNDS + 1);
   localparam int DW = tbur_pkg::DATA_W;
   localparam int WW = tbur_pkg::WIDE_W;
   localparam int AW = tbur_pkg::ACC_W;
   localparam int OW = tbur_pkg::OPND_W;

   // sequencer
   tbur_pkg::state_type              state_ff, state_in;
   logic [tbur_pkg::STEP_W-1:0]      step_ff;
   logic [tbur_pkg::STEP_W-1:0]      wb_step;
   logic                             elem_ff;
   tbur_pkg::pair_type               pair_ff;
   logic [CNT_W-1:0]                 count_ff;

   // working matrices and vector
   logic signed [DW-1:0]  a00_ff, a01_ff, a10_ff, a11_ff;
   logic signed [DW-1:0]  b00_ff, b01_ff, b10_ff, b11_ff;
   logic signed [DW-1:0]  v0_ff, v1_ff;
   logic signed [DW-1:0]  hold_ff;

   // round terms
   logic [WW-1:0]         last_ff, m2_ff, rm_ff, smag_ff;
   logic                  sneg_ff;
   logic signed [OW-1:0]  d_ff;
   logic signed [DW-1:0]  c_ff, s_ff;

   // square root and divide
   logic [WW-1:0]         rem_ff, res_ff, bit_ff, dsub_ff;
   logic [DW-2:0]         quo_ff;
   logic [WW-1:0]         sub_op, res_in;
   logic [WW:0]           diff;
   logic                  csub_ge;
   logic [DW-2:0]         quo_in;

   // shared multiplier
   tbur_pkg::mac_ctl_type    mac_ctl;
   logic signed [OW-1:0]     op_a, op_b;
   logic signed [AW-1:0]     preset, acc;

   // decode helpers
   logic                     sum_wb, m2_stop, m0_ge, sv_zero, norm_hi, norm_ok, is_v;
   logic [WW-1:0]            or_v, sv_mag, shifted;
   logic signed [AW-1:0]     acc_neg;
   logic signed [AW-31:0]    rot_q;
   logic signed [DW-1:0]     rot_val, x_val, y_val;
   logic signed [OW-1:0]     co_first, co_second;
   tbur_pkg::reg_idx_type    x_idx, y_idx;

   tbur_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .op_a   (op_a),
      .op_b   (op_b),
      .preset (preset),
      .acc    (acc)
   );

   // rotation pair operands
   assign x_idx = tbur_pkg::pair_x(pair_ff);
   assign y_idx = tbur_pkg::pair_y(pair_ff);
   assign is_v  = (pair_ff == tbur_pkg::P_V);

   always_comb begin
      case (x_idx)
         tbur_pkg::R_A00: x_val = a00_ff;
         tbur_pkg::R_A01: x_val = a01_ff;
         tbur_pkg::R_A10: x_val = a10_ff;
         tbur_pkg::R_B00: x_val = b00_ff;
         tbur_pkg::R_B01: x_val = b01_ff;
         default:         x_val = v0_ff;
      endcase
      case (y_idx)
         tbur_pkg::R_A01: y_val = a01_ff;
         tbur_pkg::R_A10: y_val = a10_ff;
         tbur_pkg::R_A11: y_val = a11_ff;
         tbur_pkg::R_B10: y_val = b10_ff;
         tbur_pkg::R_B11: y_val = b11_ff;
         default:         y_val = v1_ff;
      endcase
   end

   // phase decisions from the accumulator
   always_comb begin
      case (state_ff)
         tbur_pkg::ST_M2, tbur_pkg::ST_M0, tbur_pkg::ST_STERM: wb_step = tbur_pkg::WB_SUM3;
         tbur_pkg::ST_RTERM:                                   wb_step = tbur_pkg::WB_SUM1;
         tbur_pkg::ST_HSQ, tbur_pkg::ST_ROT:                   wb_step = tbur_pkg::WB_SUM2;
         default:                                              wb_step = '0;
      endcase
      sum_wb  = (step_ff == wb_step);
      m2_stop = (count_ff != '0) && (acc[WW-1:0] >= last_ff);
      m0_ge   = (acc[WW-1:0] >= m2_ff);
      sv_zero = (acc == '0);
      acc_neg = -acc;
      sv_mag  = acc[AW-1] ? acc_neg[WW-1:0] : acc[WW-1:0];
      or_v    = rm_ff | smag_ff;
      norm_hi = |or_v[WW-1:DW-1];
      norm_ok = !norm_hi && or_v[DW-2];
      // round by half then floor, saturate to 32 bits
      rot_q   = acc[AW-1:30];
      if (rot_q[AW-31:DW-1] == {(AW-30-DW+1){rot_q[DW-1]}}) begin
         rot_val = rot_q[DW-1:0];
      end else begin
         rot_val = rot_q[AW-31] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end
   end

   // shared compare-subtract for root and quotient bits
   always_comb begin
      sub_op  = (state_ff == tbur_pkg::ST_SQRT) ? (res_ff | bit_ff) : dsub_ff;
      diff    = {1'b0, rem_ff} - {1'b0, sub_op};
      csub_ge = !diff[WW];
      res_in  = csub_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
      quo_in  = {quo_ff[DW-3:0], csub_ge};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbur_pkg::ST_IDLE:  if (req_valid) state_in = tbur_pkg::ST_ROUND;
         tbur_pkg::ST_ROUND: begin
            state_in = (count_ff == CNT_W'(MAX_ROUNDS)) ? tbur_pkg::ST_DONE : tbur_pkg::ST_M2;
         end
         tbur_pkg::ST_M2: begin
            if (sum_wb) state_in = m2_stop ? tbur_pkg::ST_DONE : tbur_pkg::ST_M0;
         end
         tbur_pkg::ST_M0: begin
            if (sum_wb) state_in = m0_ge ? tbur_pkg::ST_RTERM : tbur_pkg::ST_NORM;
         end
         tbur_pkg::ST_RTERM: if (sum_wb) state_in = tbur_pkg::ST_STERM;
         tbur_pkg::ST_STERM: begin
            if (sum_wb) state_in = sv_zero ? tbur_pkg::ST_DONE : tbur_pkg::ST_NORM;
         end
         tbur_pkg::ST_NORM:  if (norm_ok) state_in = tbur_pkg::ST_HSQ;
         tbur_pkg::ST_HSQ:   if (sum_wb) state_in = tbur_pkg::ST_SQRT;
         tbur_pkg::ST_SQRT:  if (step_ff == tbur_pkg::SQRT_LAST) state_in = tbur_pkg::ST_DIVC;
         tbur_pkg::ST_DIVC:  if (step_ff == tbur_pkg::DIV_LAST) state_in = tbur_pkg::ST_DIVS;
         tbur_pkg::ST_DIVS:  if (step_ff == tbur_pkg::DIV_LAST) state_in = tbur_pkg::ST_ROT;
         tbur_pkg::ST_ROT: begin
            if (sum_wb && elem_ff && is_v) state_in = tbur_pkg::ST_ROUND;
         end
         tbur_pkg::ST_DONE:  if (rsp_ready) state_in = tbur_pkg::ST_IDLE;
         default:            state_in = tbur_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake and multiplier issue
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      mac_ctl   = '0;
      op_a      = '0;
      op_b      = '0;
      preset    = '0;
      co_first  = elem_ff ? tbur_pkg::sx33(s_ff) : tbur_pkg::sx33(c_ff);
      co_second = elem_ff ? tbur_pkg::sx33(c_ff) : tbur_pkg::sx33(s_ff);
      case (state_ff)
         tbur_pkg::ST_IDLE: req_ready = 1'b1;
         tbur_pkg::ST_DONE: rsp_valid = 1'b1;
         tbur_pkg::ST_M2: begin
            mac_ctl.vld   = (step_ff < 5'd3);
            mac_ctl.first = (step_ff == '0);
            case (step_ff[1:0])
               2'd0:    begin op_a = tbur_pkg::sx33(b10_ff); op_b = tbur_pkg::sx33(b10_ff); end
               2'd1:    begin op_a = tbur_pkg::sx33(b11_ff); op_b = tbur_pkg::sx33(b11_ff); end
               default: begin op_a = tbur_pkg::sx33(a10_ff); op_b = tbur_pkg::sx33(a10_ff); end
            endcase
         end
         tbur_pkg::ST_M0: begin
            mac_ctl.vld   = (step_ff < 5'd3);
            mac_ctl.first = (step_ff == '0);
            case (step_ff[1:0])
               2'd0:    begin op_a = tbur_pkg::sx33(b00_ff); op_b = tbur_pkg::sx33(b00_ff); end
               2'd1:    begin op_a = tbur_pkg::sx33(b01_ff); op_b = tbur_pkg::sx33(b01_ff); end
               default: begin op_a = tbur_pkg::sx33(a01_ff); op_b = tbur_pkg::sx33(a01_ff); end
            endcase
         end
         tbur_pkg::ST_RTERM: begin
            mac_ctl.vld   = (step_ff == '0);
            mac_ctl.first = 1'b1;
            mac_ctl.shr2  = 1'b1;
            op_a          = d_ff;
            op_b          = d_ff;
            preset        = $signed({2'b00, rm_ff});
         end
         tbur_pkg::ST_STERM: begin
            mac_ctl.vld   = (step_ff < 5'd3);
            mac_ctl.first = (step_ff == '0);
            mac_ctl.shr2  = 1'b1;
            case (step_ff[1:0])
               2'd0:    begin op_a = tbur_pkg::sx33(b00_ff); op_b = tbur_pkg::sx33(b10_ff); end
               2'd1:    begin op_a = tbur_pkg::sx33(b01_ff); op_b = tbur_pkg::sx33(b11_ff); end
               default: begin op_a = d_ff;                   op_b = tbur_pkg::sx33(a10_ff); end
            endcase
         end
         tbur_pkg::ST_HSQ: begin
            mac_ctl.vld   = (step_ff < 5'd2);
            mac_ctl.first = (step_ff == '0);
            if (step_ff == '0) begin
               op_a = $signed({2'b00, rm_ff[DW-2:0]});
               op_b = $signed({2'b00, rm_ff[DW-2:0]});
            end else begin
               op_a = $signed({2'b00, smag_ff[DW-2:0]});
               op_b = $signed({2'b00, smag_ff[DW-2:0]});
            end
         end
         tbur_pkg::ST_ROT: begin
            mac_ctl.vld   = (step_ff < 5'd2);
            mac_ctl.first = (step_ff == '0);
            preset        = tbur_pkg::HALF_Q30;
            if (step_ff == '0) begin
               op_a        = co_first;
               op_b        = tbur_pkg::sx33(x_val);
               mac_ctl.neg = elem_ff && !is_v;
            end else begin
               op_a        = co_second;
               op_b        = tbur_pkg::sx33(y_val);
               mac_ctl.neg = !elem_ff && is_v;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbur_pkg::ST_IDLE;
         step_ff  <= '0;
         elem_ff  <= 1'b0;
         pair_ff  <= tbur_pkg::P_B_COL0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_in != state_ff || (state_ff == tbur_pkg::ST_ROT && sum_wb)) begin
            step_ff <= '0;
         end else begin
            step_ff <= step_ff + 5'd1;
         end
         if (state_ff == tbur_pkg::ST_IDLE) begin
            count_ff <= '0;
         end else if (state_ff == tbur_pkg::ST_M2 && sum_wb && !m2_stop) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (state_ff != tbur_pkg::ST_ROT) begin
            elem_ff <= 1'b0;
            pair_ff <= tbur_pkg::P_B_COL0;
         end else if (sum_wb) begin
            elem_ff <= !elem_ff;
            if (elem_ff && !is_v) pair_ff <= tbur_pkg::pair_type'(pair_ff + 3'd1);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         tbur_pkg::ST_IDLE: begin
            if (req_valid) begin
               a00_ff  <= req_a_top_left;
               a01_ff  <= req_a_top_right;
               a10_ff  <= req_a_bottom_left;
               a11_ff  <= req_a_bottom_right;
               b00_ff  <= req_b_top_left;
               b01_ff  <= req_b_top_right;
               b10_ff  <= req_b_bottom_left;
               b11_ff  <= req_b_bottom_right;
               v0_ff   <= tbur_pkg::ONE_Q30;
               v1_ff   <= '0;
               last_ff <= '0;
            end
         end
         tbur_pkg::ST_M2: begin
            if (sum_wb) begin
               m2_ff <= acc[WW-1:0];
               if (!m2_stop) last_ff <= acc[WW-1:0];
               d_ff <= tbur_pkg::sx33(a00_ff) - tbur_pkg::sx33(a11_ff);
            end
         end
         tbur_pkg::ST_M0: begin
            if (sum_wb) begin
               if (m0_ge) begin
                  rm_ff <= (acc[WW-1:0] - m2_ff) >> 2;
               end else begin
                  rm_ff   <= '0;
                  smag_ff <= WW'(1);
                  sneg_ff <= 1'b0;
               end
            end
         end
         tbur_pkg::ST_RTERM: if (sum_wb) rm_ff <= acc[WW-1:0];
         tbur_pkg::ST_STERM: begin
            if (sum_wb) begin
               sneg_ff <= acc[AW-1];
               smag_ff <= sv_mag;
            end
         end
         // bring the larger term into [2^30, 2^31)
         tbur_pkg::ST_NORM: begin
            if (norm_hi) begin
               rm_ff   <= rm_ff >> 1;
               smag_ff <= smag_ff >> 1;
            end else if (!or_v[DW-2]) begin
               rm_ff   <= rm_ff << 1;
               smag_ff <= smag_ff << 1;
            end
         end
         tbur_pkg::ST_HSQ: begin
            if (sum_wb) begin
               rem_ff <= acc[WW-1:0];
               res_ff <= '0;
               bit_ff <= tbur_pkg::SQRT_BIT_TOP;
            end
         end
         // one root bit per cycle
         tbur_pkg::ST_SQRT: begin
            res_ff <= res_in;
            bit_ff <= bit_ff >> 2;
            if (step_ff == tbur_pkg::SQRT_LAST) begin
               rem_ff  <= rm_ff << 30;
               dsub_ff <= res_in << 30;
               quo_ff  <= '0;
            end else if (csub_ge) begin
               rem_ff <= diff[WW-1:0];
            end
         end
         // one quotient bit per cycle for c, then for s
         tbur_pkg::ST_DIVC: begin
            if (step_ff == tbur_pkg::DIV_LAST) begin
               c_ff    <= $signed({1'b0, quo_in});
               rem_ff  <= smag_ff << 30;
               dsub_ff <= res_ff << 30;
               quo_ff  <= '0;
            end else begin
               quo_ff  <= quo_in;
               dsub_ff <= dsub_ff >> 1;
               if (csub_ge) rem_ff <= diff[WW-1:0];
            end
         end
         tbur_pkg::ST_DIVS: begin
            if (step_ff == tbur_pkg::DIV_LAST) begin
               s_ff <= sneg_ff ? -$signed({1'b0, quo_in}) : $signed({1'b0, quo_in});
            end else begin
               quo_ff  <= quo_in;
               dsub_ff <= dsub_ff >> 1;
               if (csub_ge) rem_ff <= diff[WW-1:0];
            end
         end
         // first result waits in hold until its partner is done
         tbur_pkg::ST_ROT: begin
            if (sum_wb && !elem_ff) begin
               hold_ff <= rot_val;
            end else if (sum_wb) begin
               case (x_idx)
                  tbur_pkg::R_A00: a00_ff <= hold_ff;
                  tbur_pkg::R_A01: a01_ff <= hold_ff;
                  tbur_pkg::R_A10: a10_ff <= hold_ff;
                  tbur_pkg::R_B00: b00_ff <= hold_ff;
                  tbur_pkg::R_B01: b01_ff <= hold_ff;
                  default:         v0_ff  <= hold_ff;
               endcase
               case (y_idx)
                  tbur_pkg::R_A01: a01_ff <= rot_val;
                  tbur_pkg::R_A10: a10_ff <= rot_val;
                  tbur_pkg::R_A11: a11_ff <= rot_val;
                  tbur_pkg::R_B10: b10_ff <= rot_val;
                  tbur_pkg::R_B11: b11_ff <= rot_val;
                  default:         v1_ff  <= rot_val;
               endcase
            end
         end
         default: ;
      endcase
   end

   // response fields
   assign shifted                = last_ff >> FRAC_BITS;
   assign rsp_residual_norm      = (|shifted[WW-1:tbur_pkg::NORM_W]) ? '1 :
                                   shifted[tbur_pkg::NORM_W-1:0];
   assign rsp_v_first            = v0_ff;
   assign rsp_v_second           = v1_ff;
   assign rsp_rot_a_top_left     = a00_ff;
   assign rsp_rot_a_top_right    = a01_ff;
   assign rsp_rot_a_bottom_left  = a10_ff;
   assign rsp_rot_a_bottom_right = a11_ff;
   assign rsp_rot_b_top_left     = b00_ff;
   assign rsp_rot_b_top_right    = b01_ff;
   assign rsp_rot_b_bottom_left  = b10_ff;
   assign rsp_rot_b_bottom_right = b11_ff;

   // checks
   a_round_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ROUNDS))
      else $error("round count beyond limit");

   a_norm_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbur_pkg::ST_HSQ) |->
      (rm_ff[WW-1:DW-1] == '0 && smag_ff[WW-1:DW-1] == '0 && (rm_ff[DW-2] || smag_ff[DW-2])))
      else $error("rotation terms not normalized");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbur_pkg::ST_DIVS) |-> (c_ff >= 0 && c_ff <= tbur_pkg::ONE_Q30))
      else $error("cosine term out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == tbur_pkg::ST_ROUND && count_ff == '0))
      else $error("request accepted without starting a round");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for two_by_two_uncontrollability_rotation_unit
// drives matrix pairs, predicts rotated matrices, vector and norm; needs tbur_pkg and the unit

module tb_top;
   import tbur_pkg::*;

   typedef logic signed [DATA_W-1:0] mat_words_t [8];

   typedef struct {
      logic [NORM_W-1:0]        norm;
      logic signed [DATA_W-1:0] w[10];
   } rot_result_t;

   typedef struct {
      mat_words_t  m;
      bit          typed;
      rot_result_t want;
   } stim_row_t;

   localparam int N_RANDOM      = 540;
   localparam int LONG_HOLD     = 3000;
   localparam int DRAIN_CYCLES  = 1000;
   localparam longint LIMIT_CYC = 4_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [DATA_W-1:0] req_f[8] = '{default: '0};
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [NORM_W-1:0] rsp_norm;
   logic signed [DATA_W-1:0] rsp_f[10];

   rot_result_t rotated_q[$];
   stim_row_t   plan[$];
   int          n_errors = 0;
   int          n_taken  = 0;

   two_by_two_uncontrollability_rotation_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_top_left(req_f[0]), .req_a_top_right(req_f[1]),
      .req_a_bottom_left(req_f[2]), .req_a_bottom_right(req_f[3]),
      .req_b_top_left(req_f[4]), .req_b_top_right(req_f[5]),
      .req_b_bottom_left(req_f[6]), .req_b_bottom_right(req_f[7]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_residual_norm(rsp_norm),
      .rsp_v_first(rsp_f[0]), .rsp_v_second(rsp_f[1]),
      .rsp_rot_a_top_left(rsp_f[2]), .rsp_rot_a_top_right(rsp_f[3]),
      .rsp_rot_a_bottom_left(rsp_f[4]), .rsp_rot_a_bottom_right(rsp_f[5]),
      .rsp_rot_b_top_left(rsp_f[6]), .rsp_rot_b_top_right(rsp_f[7]),
      .rsp_rot_b_bottom_left(rsp_f[8]), .rsp_rot_b_bottom_right(rsp_f[9])
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // squared magnitude, exact in 64 bits
   function automatic logic [63:0] sq_mag(longint x);
      logic [63:0] m;
      m = (x < 0) ? -x : x;
      return m * m;
   endfunction

   // q1.30 product sum back to q16.16 with rounding and clamp
   function automatic longint round_q30(longint p);
      longint r;
      r = (p + 64'sd536870912) >>> 30;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   function automatic void turn_pair(longint c, longint s, inout longint x, inout longint y);
      longint nx, ny;
      nx = round_q30(c * x + s * y);
      ny = round_q30(-s * x + c * y);
      x = nx;
      y = ny;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // predicted outcome of the rotation rounds for one request
   function automatic rot_result_t rotate_matrices(mat_words_t m);
      longint a[2][2], b[2][2];
      longint v0, v1, sv, c, s, d, t0, t1;
      logic [63:0] last, m2, m0, rm, smag, mx, h;
      bit have_last, sneg;
      int rounds;
      rot_result_t r;
      v0 = 64'sd1073741824;
      v1 = 0;
      last = 0;
      have_last = 0;
      rounds = 0;
      for (int i = 0; i < 4; i++) begin
         a[i>>1][i&1] = m[i];
         b[i>>1][i&1] = m[4+i];
      end
      while (rounds < MAX_ROUNDS_DEF) begin
         m2 = sq_mag(b[1][0]) + sq_mag(b[1][1]) + sq_mag(a[1][0]);
         if (have_last && m2 >= last) break;
         rounds++;
         last = m2;
         have_last = 1;
         m0 = sq_mag(b[0][0]) + sq_mag(b[0][1]) + sq_mag(a[0][1]);
         if (m0 >= m2) begin
            d = a[0][0] - a[1][1];
            rm = ((m0 - m2) >> 2) + (sq_mag(d) >> 2);
            sv = ((b[0][0] * b[1][0]) >>> 2) + ((b[0][1] * b[1][1]) >>> 2)
               + ((d * a[1][0]) >>> 2);
         end else begin
            rm = 0;
            sv = 1;
         end
         // zero cross term ends the rounds without a rotation
         if (sv == 0) break;
         sneg = sv < 0;
         smag = sneg ? -sv : sv;
         mx = (rm > smag) ? rm : smag;
         while (mx >= 64'h8000_0000) begin
            mx = mx >> 1; rm = rm >> 1; smag = smag >> 1;
         end
         while (mx < 64'h4000_0000) begin
            mx = mx << 1; rm = rm << 1; smag = smag << 1;
         end
         h = int_sqrt(rm * rm + smag * smag);
         c = longint'((rm << 30) / h);
         s = longint'((smag << 30) / h);
         if (sneg) s = -s;
         for (int i = 0; i < 2; i++) turn_pair(c, s, b[0][i], b[1][i]);
         for (int i = 0; i < 2; i++) turn_pair(c, s, a[0][i], a[1][i]);
         for (int i = 0; i < 2; i++) turn_pair(c, s, a[i][0], a[i][1]);
         t0 = round_q30(c * v0 - s * v1);
         t1 = round_q30(s * v0 + c * v1);
         v0 = t0;
         v1 = t1;
      end
      r.norm = (last >> FRAC_BITS_DEF);
      r.w[0] = v0;
      r.w[1] = v1;
      for (int i = 0; i < 4; i++) begin
         r.w[2+i] = a[i>>1][i&1];
         r.w[6+i] = b[i>>1][i&1];
      end
      return r;
   endfunction

   function automatic void add_row(mat_words_t m, bit typed = 0, logic [NORM_W-1:0] nrm = 0);
      stim_row_t row;
      row.m = m;
      row.typed = typed;
      // typed rows leave matrices untouched and the vector at one
      row.want.norm = nrm;
      row.want.w[0] = ONE_Q30;
      row.want.w[1] = '0;
      for (int i = 0; i < 8; i++) row.want.w[2+i] = m[i];
      plan.push_back(row);
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_word(int kind);
      logic signed [DATA_W-1:0] x;
      case (kind)
         0: x = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         1: x = $urandom;
         2: begin
            case ($urandom_range(0, 5))
               0: x = 32'sh7fff_ffff;
               1: x = 32'sh8000_0000;
               2: x = 0;
               3: x = -1;
               4: x = 1;
               default: x = 32'sh0001_0000;
            endcase
         end
         default: x = $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000;
      endcase
      return x;
   endfunction

   // one random request, mostly mid-size values so several rounds run
   function automatic mat_words_t random_item();
      mat_words_t m;
      int pick;
      pick = $urandom_range(0, 99);
      for (int i = 0; i < 8; i++) begin
         if (pick < 45) m[i] = rand_word(0);
         else if (pick < 62) m[i] = rand_word(1);
         else if (pick < 75) m[i] = rand_word(2);
         else if (pick < 90) m[i] = (i == 2 || i >= 6) ? rand_word(3) : rand_word(0);
         else m[i] = rand_word(0);
      end
      // zero a10 and zero bottom row of B give a zero cross term
      if (pick >= 90) begin
         m[2] = 0; m[6] = 0; m[7] = 0;
      end
      return m;
   endfunction

   // offer one request and hold it until taken
   task automatic offer(mat_words_t m, stim_row_t row, bit use_row);
      req_valid <= 1'b1;
      for (int i = 0; i < 8; i++) req_f[i] <= m[i];
      do @(posedge clock); while (!req_ready);
      if (use_row && row.typed) rotated_q.push_back(row.want);
      else rotated_q.push_back(rotate_matrices(m));
   endtask

   task automatic maybe_gap(bit quiet);
      if (!quiet && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   // request side
   initial begin
      stim_row_t  dummy;
      mat_words_t m;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row('{0, 0, 0, 0, 0, 0, 0, 0}, 1, 0);
      add_row('{0, 0, 0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000}, 1, 48'h1_0000);
      add_row('{0, 0, 0, 0, 0, 0, 0, 0});
      add_row('{default: 32'sh7fff_ffff});
      add_row('{default: 32'sh8000_0000});
      add_row('{default: -1});
      add_row('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff});
      add_row('{0, 0, 0, 0, 0, 0, 32'sh0001_0000, 0});
      add_row('{0, 0, 1, 0, 0, 0, 0, 0});
      add_row('{32'sh0001_0000, 32'sh0002_0000, 32'sh0000_8000, 32'sh0003_0000,
                32'sh0002_0000, 32'sh0001_0000, 32'sh0000_4000, 32'sh0000_2000});
      add_row('{32'sh0005_0000, 0, 32'sh0001_0000, -32'sh0002_0000,
                32'sh0004_0000, -32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000});
      add_row('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                32'sh7fff_ffff, 32'sh7fff_ffff, 1, -1});
      add_row('{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555});
      add_row('{-32'sh0001_0000, 32'sh0000_0001, 32'sh0000_0010, 32'sh0001_0000,
                -32'sh0000_8000, 32'sh0000_1000, -32'sh0000_0100, 32'sh0000_0001});

      // directed table
      foreach (plan[k]) begin
         maybe_gap(0);
         offer(plan[k].m, plan[k], 1);
      end

      // random requests; a quiet stretch in the middle
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 150) begin
            req_valid <= 1'b0;
            while (rotated_q.size() != 0) @(posedge clock);
         end
         maybe_gap(n >= 300 && n < 380);
         m = random_item();
         offer(m, dummy, 0);
      end
      req_valid <= 1'b0;

      // drain and settle
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0) begin
         $display("** two_by_two_uncontrollability_rotation_unit: PASSED **");
      end else begin
         $display("** two_by_two_uncontrollability_rotation_unit: FAILED **");
      end
      $finish;
   end

   // result side: check each response, then pick the next ready level
   int hold_cnt = 0;
   bit held_once = 0;
   always @(posedge clock) begin
      rot_result_t want;
      if (rsp_valid && rsp_ready) begin
         n_taken++;
         if (rotated_q.size() == 0) begin
            n_errors++;
            $display("%0t: response with no request outstanding", $time);
         end else begin
            want = rotated_q.pop_front();
            if (rsp_norm !== want.norm) begin
               n_errors++;
               $display("%0t: residual_norm expected %0d actual %0d", $time, want.norm,
                        rsp_norm);
            end
            for (int i = 0; i < 10; i++) begin
               if (rsp_f[i] !== want.w[i]) begin
                  n_errors++;
                  $display("%0t: response word %0d expected %0d actual %0d", $time, i,
                           want.w[i], rsp_f[i]);
               end
            end
         end
      end
      // one long hold-off so the unit backs up its input
      if (!held_once && n_taken == 100) begin
         held_once <= 1;
         hold_cnt <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= (hold_cnt == 1);
      end else if (n_taken >= 250 && n_taken < 330) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 22);
      end
   end

   // run limit
   initial begin
      repeat (LIMIT_CYC) @(posedge clock);
      $display("** two_by_two_uncontrollability_rotation_unit: FAILED **");
      $finish;
   end

endmodule
